// ===== rtl/core/ntgb_pkg.sv =====
package ntgb_pkg;

  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned IMG_W      = 64;
  localparam int unsigned FONT_SHIFT = 5;
  localparam logic [4:0]  ZCNT_MAX   = 5'(BCD_DIGITS - 1);
  localparam logic [3:0]  CONV_LAST  = 4'(VALUE_W / 4 - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_NORM,
    S_FORM
  } ntgb_state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic norm;
    logic form;
  } ntgb_cmd_t;

  typedef struct packed {
    logic is_glyph;
    logic norm_done;
    logic out_free;
  } ntgb_sts_t;

  function automatic logic [IMG_W-1:0] font_rom(input logic [3:0] idx);
    logic [IMG_W-1:0] g;
    case (idx)
      4'd0:    g = 64'h40A0A0A040000000;
      4'd1:    g = 64'h40C04040E0000000;
      4'd2:    g = 64'hC0204080E0000000;
      4'd3:    g = 64'hC0204020C0000000;
      4'd4:    g = 64'h80A0E02020000000;
      4'd5:    g = 64'hE080C020C0000000;
      4'd6:    g = 64'h6080E0A0E0000000;
      4'd7:    g = 64'hE020404040000000;
      4'd8:    g = 64'hE0A0E0A0E0000000;
      4'd9:    g = 64'hE0A0E020C0000000;
      4'd10:   g = 64'h40A0E0A0A0000000;
      4'd11:   g = 64'hC0A0C0A0C0000000;
      4'd12:   g = 64'h6080808060000000;
      4'd13:   g = 64'hC0A0A0A0C0000000;
      4'd14:   g = 64'hE080C080E0000000;
      default: g = 64'hE080C08080000000;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/ntgb_ctrl.sv =====
module ntgb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ntgb_pkg::ntgb_sts_t sts,
  output ntgb_pkg::ntgb_cmd_t cmd
);
  import ntgb_pkg::*;

  ntgb_state_t state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic        in_fire;

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (sts.is_glyph) begin
          state_nxt = S_FORM;
        end else begin
          cmd.conv = 1'b1;
          step_nxt = step_r + 4'd1;
          if (step_r == CONV_LAST) begin
            state_nxt = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (sts.norm_done) begin
          state_nxt = S_FORM;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      S_FORM: begin
        if (sts.out_free) begin
          cmd.form  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_fire) |=> (state_r == S_CONV))
    else $error("accepted transaction did not start conversion");

  a_conv_to_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV && !sts.is_glyph && step_r == CONV_LAST) |=> (state_r == S_NORM))
    else $error("conversion overran its step count");

  a_form_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.form |-> sts.out_free)
    else $error("result formed while output slot occupied");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("input accepted while busy");

endmodule

// ===== rtl/core/ntgb_dp.sv =====
module ntgb_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ntgb_pkg::ntgb_cmd_t cmd,
  output ntgb_pkg::ntgb_sts_t sts,
  input  logic                in_op,
  input  logic [63:0]         in_value,
  input  logic [3:0]          in_glyph_id,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [63:0]         out_screen_bits
);
  import ntgb_pkg::*;

  logic               op_r;
  logic [3:0]         gid_r;
  logic [VALUE_W-1:0] bin_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [4:0]         zcnt_r;
  logic [IMG_W-1:0]   out_r;
  logic               out_valid_r;

  logic [IMG_W-1:0]   img_nxt;
  logic [4:0]         ndig;
  logic [4:0]         cnt;
  logic [3:0]         dig_a, dig_b, dig_c, fa, fb;

  function automatic logic [BCD_W-1:0] dabble4(input logic [BCD_W-1:0] b,
                                               input logic [3:0] bits);
    logic [BCD_W-1:0] t;
    t = b;
    for (int s = 0; s < 4; s++) begin
      for (int j = 0; j < BCD_DIGITS; j++) begin
        if (t[4*j +: 4] >= 4'd5) begin
          t[4*j +: 4] = t[4*j +: 4] + 4'd3;
        end
      end
      t = {t[BCD_W-2:0], bits[3-s]};
    end
    return t;
  endfunction

  assign dig_a = bcd_r[BCD_W-1 -: 4];
  assign dig_b = bcd_r[BCD_W-5 -: 4];
  assign dig_c = bcd_r[BCD_W-9 -: 4];
  assign ndig  = 5'(BCD_DIGITS) - zcnt_r;

  always_comb begin
    fa  = dig_a;
    fb  = dig_b;
    cnt = '0;
    if (ndig >= 5'd3) begin
      cnt = ndig - 5'd2;
      if (dig_c >= 4'd5) begin
        if (dig_b != 4'd9) begin
          fb = dig_b + 4'd1;
        end else if (dig_a != 4'd9) begin
          fa = dig_a + 4'd1;
          fb = 4'd0;
        end else begin
          fa  = 4'd1;
          fb  = 4'd0;
          cnt = cnt + 5'd1;
        end
      end
    end
    if (op_r) begin
      img_nxt = font_rom(gid_r);
    end else if (ndig == 5'd1) begin
      img_nxt = font_rom(fa) >> FONT_SHIFT;
    end else begin
      img_nxt = ~({IMG_W{1'b1}} << cnt) | font_rom(fa) | (font_rom(fb) >> FONT_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      gid_r  <= in_glyph_id;
      bin_r  <= in_value;
      bcd_r  <= '0;
      zcnt_r <= '0;
    end else if (cmd.conv) begin
      bcd_r <= dabble4(bcd_r, bin_r[VALUE_W-1 -: 4]);
      bin_r <= bin_r << 4;
    end else if (cmd.norm) begin
      bcd_r  <= bcd_r << 4;
      zcnt_r <= zcnt_r + 5'd1;
    end
    if (cmd.form) begin
      out_r <= img_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.form) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.is_glyph  = op_r;
  assign sts.norm_done = (dig_a != 4'd0) || (zcnt_r == ZCNT_MAX);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid      = out_valid_r;
  assign out_screen_bits = out_r;

  a_zcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.norm |-> (zcnt_r < ZCNT_MAX))
    else $error("leading zero count overran");

  a_form_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.form |=> out_valid_r)
    else $error("formed result not presented");

  a_norm_no_conv: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.norm && (cmd.conv || cmd.load || cmd.form)))
    else $error("conflicting datapath commands");

endmodule

// ===== rtl/core/number_to_glyph_bitmap.sv =====
// channel | dir | tdata                                  | tuser
// in_     | in  | [63:0] value, [67:64] glyph_id, pad 72 | op (0 number, 1 glyph)
// out_    | out | [63:0] screen_bits                     | -
//
// Glyph transactions: after acceptance the controller goes from S_CONV to S_FORM.
// Number transactions: the 4-bit-per-cycle BCD converter builds the
// 20-digit decimal form, then the one-digit-per-cycle normaliser strips
// its leading zero digits, at most 19, before the result forms.
// Synchronous active-low reset clears the controller and the output valid.
// Input is taken only when idle, in the cycle after the result forms; a stalled
// result holds while the next transaction converts.
module number_to_glyph_bitmap (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] value, [67:64] glyph_id, [71:68] zero
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [63:0] screen_bits
);
  import ntgb_pkg::*;

  ntgb_cmd_t cmd;
  ntgb_sts_t sts;

  ntgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ntgb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_tuser),
    .in_value        (in_tdata[63:0]),
    .in_glyph_id     (in_tdata[67:64]),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_screen_bits (out_tdata)
  );

endmodule
